// ===== sv/stk_pkg.sv =====
// Shared types and codes for the stack with middle access.
// Used by stk_cell, stk_chain and stack_with_middle_access; no dependencies.
package stk_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned S_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [VALUE_W-1:0] word_t;

    // broadcast to every cell of a chain
    typedef struct packed {
        logic shift_up;    // take the neighbour nearer the head
        logic shift_down;  // take the neighbour further from the head
        logic wr_en;       // the cell at wr_pos takes wr_data (over any shift)
    } cell_ctrl_t;

endpackage

// ===== sv/stk_cell.sv =====
// One storage cell of a chain: holds one entry and moves it to a neighbour.
// Depends on stk_pkg.
module stk_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned PW  = 1
) (
    input  logic                aclk,
    input  stk_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]       wr_pos,
    input  stk_pkg::word_t      wr_data,
    input  stk_pkg::word_t      up_data,
    input  stk_pkg::word_t      dn_data,
    output stk_pkg::word_t      data
);

    stk_pkg::word_t data_reg;
    stk_pkg::word_t data_next;

    always_comb begin
        if (ctrl.wr_en && (wr_pos == PW'(IDX))) begin
            data_next = wr_data;
        end else if (ctrl.shift_up) begin
            data_next = up_data;
        end else if (ctrl.shift_down) begin
            data_next = dn_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/stk_chain.sv =====
// A row of stk_cell instances; cell 0 is the head, fed from head_data.
// Depends on stk_pkg and stk_cell.
module stk_chain #(
    parameter int unsigned N  = 32,
    parameter int unsigned PW = 5
) (
    input  logic                aclk,
    input  stk_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]       wr_pos,
    input  stk_pkg::word_t      wr_data,
    input  stk_pkg::word_t      head_data,
    output stk_pkg::word_t      first,
    output stk_pkg::word_t      second
);

    stk_pkg::word_t cell_q [N];

    for (genvar i = 0; i < N; i++) begin : g_cell
        stk_pkg::word_t up_d;
        stk_pkg::word_t dn_d;

        if (i == 0) begin : g_head
            assign up_d = head_data;
        end else begin : g_body
            assign up_d = cell_q[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign dn_d = '0;
        end else begin : g_inner
            assign dn_d = cell_q[i+1];
        end

        stk_cell #(
            .IDX (i),
            .PW  (PW)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .wr_pos  (wr_pos),
            .wr_data (wr_data),
            .up_data (up_d),
            .dn_data (dn_d),
            .data    (cell_q[i])
        );
    end

    assign first = cell_q[0];

    if (N > 1) begin : g_second
        assign second = cell_q[1];
    end else begin : g_no_second
        assign second = '0;
    end

endmodule

// ===== sv/stack_with_middle_access.sv =====
// Bounded stack with access to its middle entry. Every request is finished in the cycle it is
// accepted and its result is registered, so it shows in the next cycle. A new request is
// taken when the result register is empty or its result leaves in the same cycle, giving one
// transaction per clock while the output keeps up; a stalled result holds off the input. The
// entries live in two chains of cells: the upper chain holds the top half with the middle entry
// fixed in its first cell, the lower chain holds the rest starting just below the middle.
// Push, insert and delete each shift the chains by at most one place, in parallel, so the
// middle is always read from a fixed cell. No clearing pass after reset is needed.
// Depends on stk_pkg, stk_chain and stk_cell.
module stack_with_middle_access #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] func, [33:2] value, [39:34] zero
    input  logic [stk_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, then entry_total, removed_value, middle_value, zero fill
    output logic [(((2 + $clog2(DEPTH + 1) + 64) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned UD  = (DEPTH + 1) / 2;
    localparam int unsigned LD  = DEPTH / 2;
    localparam int unsigned PWU = (UD > 1) ? $clog2(UD) : 1;
    localparam int unsigned PWL = (LD > 1) ? $clog2(LD) : 1;
    localparam int unsigned MW  = (((2 + CW + 64) + 7) / 8) * 8;

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            m_valid_reg;
    logic [MW-1:0]   m_data_reg;

    logic [stk_pkg::FUNC_W-1:0] func;
    stk_pkg::word_t             value;
    logic                       accept;

    logic [CW:0]     cnt_p1;
    logic [CW-1:0]   upper_cnt;
    logic [PWU-1:0]  pos_a;
    logic [PWU-1:0]  pos_a_m1;
    logic            odd;
    logic            full;
    logic            empty;

    stk_pkg::cell_ctrl_t u_ctrl;
    stk_pkg::cell_ctrl_t l_ctrl;
    logic [PWU-1:0]      u_pos;
    stk_pkg::word_t      u_wdata;
    stk_pkg::word_t      l_head;
    stk_pkg::word_t      u0;
    stk_pkg::word_t      u1;
    stk_pkg::word_t      l0;
    stk_pkg::word_t      l1_unused;

    logic [stk_pkg::STATUS_W-1:0] status;
    stk_pkg::word_t               removed;
    stk_pkg::word_t               mid_sel;
    stk_pkg::word_t               mid_out;

    assign func   = s_tdata[1:0];
    assign value  = s_tdata[33:2];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    // size of the upper half: ceil(count / 2)
    assign cnt_p1    = {1'b0, count_reg} + 1'b1;
    assign upper_cnt = cnt_p1[CW:1];
    assign pos_a     = upper_cnt[PWU-1:0];
    assign pos_a_m1  = pos_a - 1'b1;
    assign odd       = count_reg[0];
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb begin
        u_ctrl     = '0;
        l_ctrl     = '0;
        u_pos      = '0;
        u_wdata    = value;
        l_head     = value;
        status     = stk_pkg::ST_DONE;
        count_next = count_reg;
        removed    = '0;
        mid_sel    = u0;
        case (func)
            stk_pkg::FUNC_PUSH: begin
                if (full) begin
                    status = stk_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                    if (!odd) begin
                        // halves equal: upper half grows at the top end
                        u_ctrl.wr_en = accept;
                        u_pos        = pos_a;
                        mid_sel      = empty ? value : u0;
                    end else begin
                        // middle moves down into the lower half
                        u_ctrl.shift_down = accept;
                        u_ctrl.wr_en      = accept;
                        u_pos             = pos_a_m1;
                        l_ctrl.shift_up   = accept;
                        l_head            = u0;
                        mid_sel           = (count_reg == CW'(1)) ? value : u1;
                    end
                end
            end
            stk_pkg::FUNC_INSERT: begin
                if (full) begin
                    status = stk_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                    if (!odd) begin
                        // new entry becomes the middle
                        u_ctrl.shift_up = accept;
                        mid_sel         = value;
                    end else begin
                        l_ctrl.shift_up = accept;
                        l_head          = value;
                        mid_sel         = u0;
                    end
                end
            end
            stk_pkg::FUNC_DELETE: begin
                if (empty) begin
                    status = stk_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                    removed    = u0;
                    if (odd) begin
                        u_ctrl.shift_down = accept;
                        mid_sel           = u1;
                    end else begin
                        // entry just below the middle takes its place
                        u_ctrl.wr_en      = accept;
                        u_pos             = '0;
                        u_wdata           = l0;
                        l_ctrl.shift_down = accept;
                        mid_sel           = l0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign mid_out = (count_next == '0) ? '0 : mid_sel;

    stk_chain #(
        .N  (UD),
        .PW (PWU)
    ) u_upper (
        .aclk      (aclk),
        .ctrl      (u_ctrl),
        .wr_pos    (u_pos),
        .wr_data   (u_wdata),
        .head_data (value),
        .first     (u0),
        .second    (u1)
    );

    stk_chain #(
        .N  (LD),
        .PW (PWL)
    ) u_lower (
        .aclk      (aclk),
        .ctrl      (l_ctrl),
        .wr_pos    ('0),
        .wr_data   (value),
        .head_data (l_head),
        .first     (l0),
        .second    (l1_unused)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= MW'({mid_out, removed, count_next, status});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== tb/tb_stack_with_middle_access.sv =====
// Self-checking testbench for stack_with_middle_access: directed table, then random bursts.
// Typed rows give their results, others come from a queue-based model; compared per field.
// Depends on stk_pkg and the stack_with_middle_access RTL.
`timescale 1ns / 100ps

module tb_stack_with_middle_access;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned TOTAL_W     = $clog2(DEPTH + 1);
    localparam int unsigned RES_W       = stk_pkg::STATUS_W + TOTAL_W + 2 * stk_pkg::VALUE_W;
    localparam int unsigned M_TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int unsigned RANDOM_REQS = 1130;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // func code 3 has no operation behind it
    localparam logic [stk_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // one result transaction, status in the lowest bits
    typedef struct packed {
        stk_pkg::word_t               middle_value;
        stk_pkg::word_t               removed_value;
        logic [TOTAL_W-1:0]           entry_total;
        logic [stk_pkg::STATUS_W-1:0] status;
    } stack_result_t;

    typedef struct {
        logic [stk_pkg::FUNC_W-1:0] func;
        stk_pkg::word_t             value;
        bit                         typed;
        stack_result_t              want;
    } table_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [stk_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [M_TDATA_W-1:0]            m_tdata;

    stk_pkg::word_t  stack_image[$];     // index 0 is the top
    stack_result_t   pending_results[$];
    table_row_t      directed_rows[$];

    int unsigned cycle_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned full_rejects  = 0;
    int unsigned empty_deletes = 0;
    int unsigned peak_total    = 0;
    int unsigned burst_left    = 0;
    bit          hold_done     = 1'b0;

    stack_with_middle_access #(.DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int unsigned middle_pos(int unsigned n);
        return (n - 1) / 2;
    endfunction

    // Applies one request to the stack image and returns what the block should report.
    function automatic stack_result_t next_stack_result(logic [stk_pkg::FUNC_W-1:0] func,
                                                        stk_pkg::word_t value);
        stack_result_t res;
        int unsigned   pos;
        res = '0;
        res.status = stk_pkg::ST_DONE;
        case (func)
            stk_pkg::FUNC_PUSH: begin
                if (stack_image.size() >= DEPTH) res.status = stk_pkg::ST_FULL;
                else stack_image.push_front(value);
            end
            stk_pkg::FUNC_INSERT: begin
                if (stack_image.size() >= DEPTH) begin
                    res.status = stk_pkg::ST_FULL;
                end else if (stack_image.size() == 0) begin
                    stack_image.push_front(value);
                end else begin
                    pos = middle_pos(stack_image.size()) + 1;
                    if (pos == stack_image.size()) stack_image.push_back(value);
                    else stack_image.insert(pos, value);
                end
            end
            stk_pkg::FUNC_DELETE: begin
                if (stack_image.size() == 0) begin
                    res.status = stk_pkg::ST_EMPTY;
                end else begin
                    pos = middle_pos(stack_image.size());
                    res.removed_value = stack_image[pos];
                    stack_image.delete(pos);
                end
            end
            default: ;
        endcase
        if (res.status == stk_pkg::ST_FULL) full_rejects++;
        if (res.status == stk_pkg::ST_EMPTY) empty_deletes++;
        res.entry_total = TOTAL_W'(stack_image.size());
        if (stack_image.size() > peak_total) peak_total = stack_image.size();
        if (stack_image.size() > 0) res.middle_value = stack_image[middle_pos(stack_image.size())];
        return res;
    endfunction

    task automatic add_row(logic [stk_pkg::FUNC_W-1:0] func, stk_pkg::word_t value, bit typed,
                           logic [stk_pkg::STATUS_W-1:0] st, int unsigned total,
                           stk_pkg::word_t removed, stk_pkg::word_t middle);
        table_row_t row;
        row.func  = func;
        row.value = value;
        row.typed = typed;
        row.want.status        = st;
        row.want.entry_total   = TOTAL_W'(total);
        row.want.removed_value = removed;
        row.want.middle_value  = middle;
        directed_rows.push_back(row);
    endtask

    // Offers one request, waits for its transaction, then records the expectation.
    task automatic send_request(logic [stk_pkg::FUNC_W-1:0] func, stk_pkg::word_t value,
                                bit typed, stack_result_t typed_res);
        int unsigned   gap;
        stack_result_t model_res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(stk_pkg::S_TDATA_W - stk_pkg::FUNC_W - stk_pkg::VALUE_W){1'b0}},
                     value, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_res = next_stack_result(func, value);
        pending_results.push_back(typed ? typed_res : model_res);
        requests_sent++;
    endtask

    function automatic stk_pkg::word_t pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mode 0 grows the stack, 1 drains it, 2 mixes both
    function automatic logic [stk_pkg::FUNC_W-1:0] pick_func(int unsigned mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return FUNC_UNUSED;
        case (mode)
            0:       return (r < 95) ? (($urandom_range(0, 1) == 0) ? stk_pkg::FUNC_PUSH
                                                                    : stk_pkg::FUNC_INSERT)
                                     : stk_pkg::FUNC_DELETE;
            1:       return (r < 90) ? stk_pkg::FUNC_DELETE
                                     : (($urandom_range(0, 1) == 0) ? stk_pkg::FUNC_PUSH
                                                                    : stk_pkg::FUNC_INSERT);
            default: return (r < 52) ? stk_pkg::FUNC_DELETE
                                     : (($urandom_range(0, 1) == 0) ? stk_pkg::FUNC_PUSH
                                                                    : stk_pkg::FUNC_INSERT);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned   i;
        int unsigned   phase_left;
        int unsigned   phase_no;
        int unsigned   mode;
        stack_result_t none;
        none     = '0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stack, unused code, insert into empty and into a single entry, drain past empty
        add_row(stk_pkg::FUNC_DELETE, 32'h1234_5678, 1, stk_pkg::ST_EMPTY, 0, 32'h0, 32'h0);
        add_row(FUNC_UNUSED,          32'hFFFF_FFFF, 1, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1, stk_pkg::ST_DONE,  1, 32'h0,
                32'h7FFF_FFFF);
        add_row(stk_pkg::FUNC_INSERT, 32'h8000_0000, 1, stk_pkg::ST_DONE,  2, 32'h0,
                32'h7FFF_FFFF);
        add_row(stk_pkg::FUNC_PUSH,   32'hFFFF_FFFF, 1, stk_pkg::ST_DONE,  3, 32'h0,
                32'h7FFF_FFFF);
        add_row(FUNC_UNUSED,          32'hAAAA_AAAA, 1, stk_pkg::ST_DONE,  3, 32'h0,
                32'h7FFF_FFFF);
        add_row(stk_pkg::FUNC_DELETE, 32'h0000_0000, 1, stk_pkg::ST_DONE,  2, 32'h7FFF_FFFF,
                32'hFFFF_FFFF);
        add_row(stk_pkg::FUNC_DELETE, 32'h5555_5555, 1, stk_pkg::ST_DONE,  1, 32'hFFFF_FFFF,
                32'h8000_0000);
        add_row(stk_pkg::FUNC_DELETE, 32'h0000_0000, 1, stk_pkg::ST_DONE,  0, 32'h8000_0000,
                32'h0);
        add_row(stk_pkg::FUNC_DELETE, 32'hFFFF_FFFF, 1, stk_pkg::ST_EMPTY, 0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_PUSH,   32'h0000_0000, 1, stk_pkg::ST_DONE,  1, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_PUSH,   32'h5555_5555, 1, stk_pkg::ST_DONE,  2, 32'h0,
                32'h5555_5555);
        add_row(stk_pkg::FUNC_INSERT, 32'h0000_0001, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_INSERT, 32'hFFFF_FFFE, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_PUSH,   32'h8000_0001, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_DELETE, 32'h0000_0000, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(stk_pkg::FUNC_DELETE, 32'h0000_0000, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);
        add_row(FUNC_UNUSED,          32'h5555_5555, 0, stk_pkg::ST_DONE,  0, 32'h0, 32'h0);

        foreach (directed_rows[r])
            send_request(directed_rows[r].func, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].want);

        // phases biased to fill to full, drain to empty, or wander in between
        phase_left = 0;
        phase_no   = 0;
        mode       = 0;
        for (i = 0; i < RANDOM_REQS; i++) begin
            if (phase_left == 0) begin
                mode       = (phase_no < 3) ? phase_no : $urandom_range(0, 2);
                phase_left = (mode == 2) ? $urandom_range(20, 120) : $urandom_range(80, 140);
                phase_no++;
            end
            phase_left--;
            send_request(pick_func(mode), pick_value(), 0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d requests, %0d results checked, peak depth %0d of %0d.",
                 requests_sent, results_seen, peak_total, DEPTH);
        $display("Full rejections %0d, deletes on empty %0d, long output hold-off %0s.",
                 full_rejects, empty_deletes, hold_done ? "done" : "missed");
        if (mismatches == 0) begin
            $display("PASS stack_with_middle_access");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL stack_with_middle_access");
        end
        $finish;
    end

    // Output side stalls in segments of differing density, plus one long hold-off.
    initial begin : sink
        int unsigned seg_len;
        int unsigned seg_mode;
        int unsigned k;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && requests_sent >= 500) begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                hold_done = 1'b1;
            end
            seg_len  = $urandom_range(8, 64);
            seg_mode = $urandom_range(0, 3);
            for (k = 0; k < seg_len; k++) begin
                case (seg_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (k % 3 == 2);
                endcase
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        stack_result_t got;
        stack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RES_W-1:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: status %0d total %0d rm %h mid %h",
                             got.status, got.entry_total, got.removed_value, got.middle_value);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.entry_total !== want.entry_total ||
                    got.removed_value !== want.removed_value ||
                    got.middle_value !== want.middle_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: status %0d/%0d total %0d/%0d rm %h/%h mid %h/%h",
                                 results_seen, want.status, got.status,
                                 want.entry_total, got.entry_total,
                                 want.removed_value, got.removed_value,
                                 want.middle_value, got.middle_value);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL stack_with_middle_access");
            $finish;
        end
    end

endmodule

// ===== stack_with_middle_access.f =====
sv/stk_pkg.sv
sv/stk_cell.sv
sv/stk_chain.sv
sv/stack_with_middle_access.sv
tb/tb_stack_with_middle_access.sv
